[design/pcct_pkg.sv]
package pcct_pkg;

   localparam int unsigned DATA_W = 32;
   localparam int unsigned REG_W  = 31;
   localparam int unsigned OPA_W  = 33;
   localparam int unsigned OPB_W  = 32;
   localparam int unsigned PROD_W = OPA_W + OPB_W;
   localparam int unsigned IDX_W  = 3;

   localparam logic [IDX_W-1:0] REG_KP      = 3'd0;
   localparam logic [IDX_W-1:0] REG_KI      = 3'd1;
   localparam logic [IDX_W-1:0] REG_KD      = 3'd2;
   localparam logic [IDX_W-1:0] REG_P_LIM   = 3'd3;
   localparam logic [IDX_W-1:0] REG_I_LIM   = 3'd4;
   localparam logic [IDX_W-1:0] REG_D_LIM   = 3'd5;

   typedef enum logic [8:0] {
      ST_IDLE  = 9'b000000001,
      ST_MULQ  = 9'b000000010,
      ST_QEST  = 9'b000000100,
      ST_QFIX  = 9'b000001000,
      ST_INTEG = 9'b000010000,
      ST_TERMP = 9'b000100000,
      ST_TERMI = 9'b001000000,
      ST_TERMD = 9'b010000000,
      ST_SUM   = 9'b100000000
   } state_type;

   // symmetric clamp to +-lim, result always fits 32 bits
   function automatic logic signed [DATA_W-1:0] clamp_sym(
      input logic signed [PROD_W-1:0] v,
      input logic [REG_W-1:0]         lim
   );
      logic signed [PROD_W-1:0] hi;
      logic signed [PROD_W-1:0] lo;
      logic signed [PROD_W-1:0] res;
      hi = $signed({{(PROD_W-REG_W){1'b0}}, lim});
      lo = -hi;
      if (v > hi) begin
         res = hi;
      end else if (v < lo) begin
         res = lo;
      end else begin
         res = v;
      end
      return res[DATA_W-1:0];
   endfunction

   function automatic logic signed [DATA_W-1:0] sat32(
      input logic signed [PROD_W-1:0] v
   );
      logic signed [PROD_W-1:0] hi;
      logic signed [PROD_W-1:0] lo;
      logic signed [DATA_W-1:0] res;
      hi = $signed({{(PROD_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}});
      lo = $signed({{(PROD_W-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}});
      if (v > hi) begin
         res = hi[DATA_W-1:0];
      end else if (v < lo) begin
         res = lo[DATA_W-1:0];
      end else begin
         res = v[DATA_W-1:0];
      end
      return res;
   endfunction

   // Q16.16 gain product: add half, floor shift by 16, saturate
   function automatic logic signed [DATA_W-1:0] round_sat(
      input logic signed [PROD_W-1:0] p
   );
      logic signed [PROD_W-1:0] x;
      logic signed [PROD_W-1:0] sh;
      x  = p + $signed(PROD_W'(32'h0000_8000));
      sh = x >>> 16;
      return sat32(sh);
   endfunction

endpackage

[design/pcct_if.sv]
interface pcct_req_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [pcct_pkg::DATA_W-1:0]     error_sample;

   modport source (output valid, output error_sample, input ready);
   modport sink   (input valid, input error_sample, output ready);
endinterface

interface pcct_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [pcct_pkg::DATA_W-1:0]     correction;
   logic signed [pcct_pkg::DATA_W-1:0]     term_p;
   logic signed [pcct_pkg::DATA_W-1:0]     term_i;
   logic signed [pcct_pkg::DATA_W-1:0]     term_d;

   modport source (output valid, output correction, output term_p, output term_i,
                   output term_d, input ready);
   modport sink   (input valid, input correction, input term_p, input term_i,
                   input term_d, output ready);
endinterface

[design/pcct_mul.sv]
module pcct_mul (
   input  logic                                   clock,
   input  logic signed [pcct_pkg::OPA_W-1:0]      op_a,
   input  logic        [pcct_pkg::OPB_W-1:0]      op_b,
   output logic signed [pcct_pkg::PROD_W-1:0]     product
);

   logic signed [pcct_pkg::PROD_W-1:0] prod_ff;
   logic signed [pcct_pkg::PROD_W-1:0] prod_in;
   logic signed [pcct_pkg::PROD_W-1:0] a_ext;
   logic signed [pcct_pkg::PROD_W-1:0] b_ext;

   always_comb begin
      a_ext   = {{(pcct_pkg::PROD_W-pcct_pkg::OPA_W){op_a[pcct_pkg::OPA_W-1]}}, op_a};
      b_ext   = $signed({{(pcct_pkg::PROD_W-pcct_pkg::OPB_W){1'b0}}, op_b});
      prod_in = a_ext * b_ext;
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign product = prod_ff;

endmodule

[design/pid_corrector_clamped_terms.sv]
// PID corrector, parallel form, signed Q16.16. Each req beat carries one error
// sample; one rsp beat returns the P, I and D terms and their saturated sum.
// A single registered multiplier is shared by all steps: two multiplies for
// error/SAMPLE_FREQ (reciprocal estimate and one-step fix), one for the
// derivative scale and three for the gains. req is ready only while the
// sequencer is idle, so a sample is taken only after the last result is
// loaded; a finished result waits in the output register while the next
// sample is taken. Gains and limits must be written through the csr port
// while no sample is in work; the block itself does not enforce this.
module pid_corrector_clamped_terms #(
   parameter int unsigned SAMPLE_FREQ = 250
) (
   input  logic                              clock,
   input  logic                              reset,
   pcct_req_if.sink                          req_bus,
   pcct_rsp_if.source                        rsp_bus,
   input  logic                              csr_wr_en,
   input  logic [pcct_pkg::IDX_W-1:0]        csr_index,
   input  logic [pcct_pkg::REG_W-1:0]        csr_wdata
);

   localparam int unsigned LOG_F  = $clog2(SAMPLE_FREQ);
   localparam int unsigned SHIFT  = 31 + LOG_F;
   localparam logic [63:0] RECIP_WIDE = (64'd1 << SHIFT) / 64'(SAMPLE_FREQ);
   localparam logic [pcct_pkg::OPB_W-1:0] RECIP = RECIP_WIDE[pcct_pkg::OPB_W-1:0];
   localparam logic [pcct_pkg::OPB_W-1:0] FREQ_B = pcct_pkg::OPB_W'(SAMPLE_FREQ);
   localparam logic [pcct_pkg::OPA_W-1:0] FREQ_R = pcct_pkg::OPA_W'(SAMPLE_FREQ);

   pcct_pkg::state_type state_ff, state_in;

   logic [pcct_pkg::REG_W-1:0] kp_ff, ki_ff, kd_ff;
   logic [pcct_pkg::REG_W-1:0] p_lim_ff, i_lim_ff, d_lim_ff;

   logic signed [pcct_pkg::DATA_W-1:0] e_ff, prev_ff, integ_ff, der_ff;
   logic signed [pcct_pkg::DATA_W-1:0] tp_ff, ti_ff, td_ff;
   logic        [pcct_pkg::OPA_W-1:0]  mag_ff, mag_in;
   logic        [pcct_pkg::DATA_W-1:0] q_ff, q0;
   logic        [pcct_pkg::OPA_W-1:0]  rem;

   logic                               out_valid_ff;
   logic signed [pcct_pkg::DATA_W-1:0] out_corr_ff, out_p_ff, out_i_ff, out_d_ff;

   logic signed [pcct_pkg::OPA_W-1:0]  mul_a;
   logic        [pcct_pkg::OPB_W-1:0]  mul_b;
   logic signed [pcct_pkg::PROD_W-1:0] prod;

   logic signed [pcct_pkg::OPA_W-1:0]  e_ext, diff, inc;
   logic signed [pcct_pkg::OPA_W:0]    acc;
   logic signed [pcct_pkg::DATA_W-1:0] p_opd;
   logic signed [pcct_pkg::DATA_W+1:0] sum;
   logic                               load_out;

   pcct_mul u_mul (
      .clock   (clock),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .product (prod)
   );

   always_comb begin
      e_ext  = {e_ff[pcct_pkg::DATA_W-1], e_ff};
      mag_in = e_ff[pcct_pkg::DATA_W-1] ? pcct_pkg::OPA_W'(-e_ext)
                                        : pcct_pkg::OPA_W'(e_ext);
      q0     = pcct_pkg::DATA_W'($unsigned(prod) >> SHIFT);
      rem    = mag_ff - prod[pcct_pkg::OPA_W-1:0];
      diff   = e_ext - {prev_ff[pcct_pkg::DATA_W-1], prev_ff};
      inc    = e_ff[pcct_pkg::DATA_W-1] ? -$signed({1'b0, q_ff}) : $signed({1'b0, q_ff});
      acc    = {{2{integ_ff[pcct_pkg::DATA_W-1]}}, integ_ff} + {inc[pcct_pkg::OPA_W-1], inc};
      p_opd  = pcct_pkg::clamp_sym(
                  {{(pcct_pkg::PROD_W-pcct_pkg::DATA_W){e_ff[pcct_pkg::DATA_W-1]}}, e_ff},
                  p_lim_ff);
      sum    = {{2{tp_ff[pcct_pkg::DATA_W-1]}}, tp_ff}
             + {{2{ti_ff[pcct_pkg::DATA_W-1]}}, ti_ff}
             + {{2{td_ff[pcct_pkg::DATA_W-1]}}, td_ff};
      load_out = (state_ff == pcct_pkg::ST_SUM) && (!out_valid_ff || rsp_bus.ready);
   end

   // shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         pcct_pkg::ST_MULQ: begin
            mul_a = $signed(mag_in);
            mul_b = RECIP;
         end
         pcct_pkg::ST_QEST: begin
            mul_a = $signed({1'b0, q0});
            mul_b = FREQ_B;
         end
         pcct_pkg::ST_QFIX: begin
            mul_a = diff;
            mul_b = FREQ_B;
         end
         pcct_pkg::ST_INTEG: begin
            mul_a = {p_opd[pcct_pkg::DATA_W-1], p_opd};
            mul_b = {1'b0, kp_ff};
         end
         pcct_pkg::ST_TERMP: begin
            mul_a = {integ_ff[pcct_pkg::DATA_W-1], integ_ff};
            mul_b = {1'b0, ki_ff};
         end
         pcct_pkg::ST_TERMI: begin
            mul_a = {der_ff[pcct_pkg::DATA_W-1], der_ff};
            mul_b = {1'b0, kd_ff};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pcct_pkg::ST_IDLE:  if (req_bus.valid) state_in = pcct_pkg::ST_MULQ;
         pcct_pkg::ST_MULQ:  state_in = pcct_pkg::ST_QEST;
         pcct_pkg::ST_QEST:  state_in = pcct_pkg::ST_QFIX;
         pcct_pkg::ST_QFIX:  state_in = pcct_pkg::ST_INTEG;
         pcct_pkg::ST_INTEG: state_in = pcct_pkg::ST_TERMP;
         pcct_pkg::ST_TERMP: state_in = pcct_pkg::ST_TERMI;
         pcct_pkg::ST_TERMI: state_in = pcct_pkg::ST_TERMD;
         pcct_pkg::ST_TERMD: state_in = pcct_pkg::ST_SUM;
         pcct_pkg::ST_SUM:   if (load_out) state_in = pcct_pkg::ST_IDLE;
         default:            state_in = pcct_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pcct_pkg::ST_IDLE;
         out_valid_ff <= 1'b0;
         kp_ff        <= '0;
         ki_ff        <= '0;
         kd_ff        <= '0;
         p_lim_ff     <= '0;
         i_lim_ff     <= '0;
         d_lim_ff     <= '0;
         integ_ff     <= '0;
         prev_ff      <= '0;
      end else begin
         state_ff <= state_in;
         if (load_out) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            out_valid_ff <= 1'b0;
         end
         if (csr_wr_en) begin
            case (csr_index)
               pcct_pkg::REG_KP:    kp_ff    <= csr_wdata;
               pcct_pkg::REG_KI:    ki_ff    <= csr_wdata;
               pcct_pkg::REG_KD:    kd_ff    <= csr_wdata;
               pcct_pkg::REG_P_LIM: p_lim_ff <= csr_wdata;
               pcct_pkg::REG_I_LIM: i_lim_ff <= csr_wdata;
               pcct_pkg::REG_D_LIM: d_lim_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (state_ff == pcct_pkg::ST_INTEG) begin
            integ_ff <= pcct_pkg::clamp_sym(
                           {{(pcct_pkg::PROD_W-pcct_pkg::OPA_W-1){acc[pcct_pkg::OPA_W]}}, acc},
                           i_lim_ff);
            prev_ff  <= e_ff;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (state_ff == pcct_pkg::ST_IDLE && req_bus.valid) begin
         e_ff <= req_bus.error_sample;
      end
      if (state_ff == pcct_pkg::ST_MULQ) begin
         mag_ff <= mag_in;
      end
      if (state_ff == pcct_pkg::ST_QEST) begin
         q_ff <= q0;
      end
      // estimate is low by at most one
      if (state_ff == pcct_pkg::ST_QFIX && rem >= FREQ_R) begin
         q_ff <= q_ff + pcct_pkg::DATA_W'(1);
      end
      if (state_ff == pcct_pkg::ST_INTEG) begin
         der_ff <= pcct_pkg::clamp_sym(prod, d_lim_ff);
      end
      if (state_ff == pcct_pkg::ST_TERMP) begin
         tp_ff <= pcct_pkg::round_sat(prod);
      end
      if (state_ff == pcct_pkg::ST_TERMI) begin
         ti_ff <= pcct_pkg::round_sat(prod);
      end
      if (state_ff == pcct_pkg::ST_TERMD) begin
         td_ff <= pcct_pkg::round_sat(prod);
      end
      if (load_out) begin
         out_corr_ff <= pcct_pkg::sat32(
                           {{(pcct_pkg::PROD_W-pcct_pkg::DATA_W-2){sum[pcct_pkg::DATA_W+1]}}, sum});
         out_p_ff    <= tp_ff;
         out_i_ff    <= ti_ff;
         out_d_ff    <= td_ff;
      end
   end

   assign req_bus.ready      = (state_ff == pcct_pkg::ST_IDLE);
   assign rsp_bus.valid      = out_valid_ff;
   assign rsp_bus.correction = out_corr_ff;
   assign rsp_bus.term_p     = out_p_ff;
   assign rsp_bus.term_i     = out_i_ff;
   assign rsp_bus.term_d     = out_d_ff;

endmodule
